// File: src/cbs_pkg.sv
// Package for the cubic Bezier sampler: widths, types and lerp arithmetic.
// Used by every module and interface of the block.
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;

    localparam int MAX_POINTS     = 64;
    localparam int MIN_POINTS     = 2;
    localparam int CONTROL_POINTS = 4;
    localparam int AXES           = 3;
    localparam int FRACTION_BITS  = 16;
    localparam int COORD_W        = 32;
    localparam int CFG_W          = 7;
    localparam int IDX_W          = 6;
    localparam int CNT_RESET      = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int T_W            = FRACTION_BITS + 1;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = DIFF_W + T_W + 1;
    localparam int SUM_W          = DIFF_W + 2;
    localparam int BCNT_W         = $clog2(FRACTION_BITS + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [T_W-1:0]            tval_t;
    typedef logic [IDX_W-1:0]          idx_t;

    typedef struct packed {
        coord_t [CONTROL_POINTS-1:0][AXES-1:0] cp;
        idx_t                                  d;
        tval_t                                 q0;
        idx_t                                  r0;
    } job_t;

    typedef struct packed {
        idx_t idx;
        logic last;
    } meta_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
        logic       empty;
    } fifo_stat_t;

    function automatic prod_t lerp_mul(coord_t a, coord_t b, tval_t t);
        logic signed [DIFF_W-1:0] diff;
        logic signed [T_W:0]      ts;
        diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        ts   = $signed({1'b0, t});
        return PROD_W'(diff) * PROD_W'(ts);
    endfunction

    function automatic coord_t lerp_sum(coord_t a, prod_t p);
        prod_t            sh;
        logic [SUM_W-1:0] s;
        coord_t           r;
        sh = p >>> FRACTION_BITS;
        s  = {{(SUM_W-COORD_W){a[COORD_W-1]}}, a} + sh[SUM_W-1:0];
        if ((&s[SUM_W-1:COORD_W-1]) || !(|s[SUM_W-1:COORD_W-1])) begin
            r = s[COORD_W-1:0];
        end else if (s[SUM_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/cbs_if.sv
// Handshake interfaces of the sampler: control point words in, curve point words out.
// Depends on cbs_pkg for the coordinate and index types.
`timescale 1ns / 1ps
`default_nettype none
interface cbs_ctrl_if;
    import cbs_pkg::*;
    logic   valid;
    logic   ready;
    coord_t p0_x, p0_y, p0_z;
    coord_t p1_x, p1_y, p1_z;
    coord_t p2_x, p2_y, p2_z;
    coord_t p3_x, p3_y, p3_z;
    modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
    modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface cbs_point_if;
    import cbs_pkg::*;
    logic   valid;
    logic   ready;
    coord_t point_x, point_y, point_z;
    idx_t   sample_index;
    logic   last_point;
    modport source (output valid, point_x, point_y, point_z, sample_index, last_point,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, sample_index, last_point,
                    output ready);
endinterface
`default_nettype wire

// File: src/cbs_front.sv
// Front end: holds the sample count register, accepts a control set, clamps the count
// and derives the parameter step by a bit-serial divide. Depends on cbs_pkg, cbs_if.
`timescale 1ns / 1ps
`default_nettype none
module cbs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_wdata,
    cbs_ctrl_if.sink           cp,
    output      logic          push_valid,
    output      cbs_pkg::job_t push_job,
    input  wire logic          push_ready
);
    import cbs_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_DIVIDE = 3'b010,
        F_PUSH   = 3'b100
    } front_state_t;

    front_state_t                          state_reg, state_next;
    logic [CFG_W-1:0]                      point_count_reg;
    coord_t [CONTROL_POINTS-1:0][AXES-1:0] cp_reg;
    idx_t                                  d_reg, d_next;
    idx_t                                  rem_reg, rem_next;
    tval_t                                 quo_reg, quo_next;
    logic [BCNT_W-1:0]                     bit_cnt_reg, bit_cnt_next;
    logic [CFG_W-1:0]                      n_clamped;
    logic [IDX_W:0]                        trial;
    logic                                  accept;

    assign cp.ready = (state_reg == F_IDLE);
    assign accept   = cp.valid && cp.ready;

    always_comb
    begin
        if (point_count_reg < CFG_W'(MIN_POINTS)) begin
            n_clamped = CFG_W'(MIN_POINTS);
        end else if (point_count_reg > CFG_W'(MAX_POINTS)) begin
            n_clamped = CFG_W'(MAX_POINTS);
        end else begin
            n_clamped = point_count_reg;
        end
    end

    assign trial = {rem_reg, bit_cnt_reg == BCNT_W'(FRACTION_BITS)};

    always_comb
    begin
        state_next   = state_reg;
        d_next       = d_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept) begin
                    d_next       = IDX_W'(n_clamped - CFG_W'(1));
                    rem_next     = '0;
                    quo_next     = '0;
                    bit_cnt_next = BCNT_W'(FRACTION_BITS);
                    state_next   = F_DIVIDE;
                end
            end
            F_DIVIDE:
            begin
                if (trial >= {1'b0, d_reg}) begin
                    rem_next = IDX_W'(trial - {1'b0, d_reg});
                    quo_next = {quo_reg[T_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[IDX_W-1:0];
                    quo_next = {quo_reg[T_W-2:0], 1'b0};
                end
                if (bit_cnt_reg == '0) begin
                    state_next = F_PUSH;
                end else begin
                    bit_cnt_next = bit_cnt_reg - BCNT_W'(1);
                end
            end
            F_PUSH:
            begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= F_IDLE;
            point_count_reg <= CFG_W'(CNT_RESET);
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                point_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        bit_cnt_reg <= bit_cnt_next;
        if (accept) begin
            cp_reg[0][0] <= cp.p0_x;
            cp_reg[0][1] <= cp.p0_y;
            cp_reg[0][2] <= cp.p0_z;
            cp_reg[1][0] <= cp.p1_x;
            cp_reg[1][1] <= cp.p1_y;
            cp_reg[1][2] <= cp.p1_z;
            cp_reg[2][0] <= cp.p2_x;
            cp_reg[2][1] <= cp.p2_y;
            cp_reg[2][2] <= cp.p2_z;
            cp_reg[3][0] <= cp.p3_x;
            cp_reg[3][1] <= cp.p3_y;
            cp_reg[3][2] <= cp.p3_z;
        end
    end

    assign push_valid  = (state_reg == F_PUSH);
    assign push_job.cp = cp_reg;
    assign push_job.d  = d_reg;
    assign push_job.q0 = quo_reg;
    assign push_job.r0 = rem_reg;

endmodule
`default_nettype wire

// File: src/cbs_queue.sv
// Two-entry job queue between the front end and the sample engine.
// Depends on cbs_pkg for the job and status types.
`timescale 1ns / 1ps
`default_nettype none
module cbs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    input  wire cbs_pkg::job_t   push_job,
    output      logic            push_ready,
    output      logic            pop_valid,
    output      cbs_pkg::job_t   pop_job,
    input  wire logic            pop_ready,
    output      cbs_pkg::fifo_stat_t stat
);
    import cbs_pkg::*;

    job_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign stat.count = count_reg;
    assign stat.full  = !push_ready;
    assign stat.empty = !pop_valid;

endmodule
`default_nettype wire

// File: src/cbs_back.sv
// Sample engine: steps the parameter for the job at the queue head and runs the three
// de Casteljau levels through a six-stage lerp pipeline. Depends on cbs_pkg, cbs_if.
`timescale 1ns / 1ps
`default_nettype none
module cbs_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire cbs_pkg::job_t job,
    output      logic          job_pop,
    cbs_point_if.source        pt
);
    import cbs_pkg::*;

    idx_t           i_reg, i_next;
    tval_t          t_reg, t_next;
    idx_t           r_reg, r_next;
    logic [IDX_W:0] rsum;
    tval_t          t_step;
    logic           carry, last_i, adv, issue;

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    meta_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    tval_t t1_reg, t2_reg, t3_reg, t4_reg;

    prod_t  [AXES-1:0][2:0] prod1_reg;
    coord_t [AXES-1:0][2:0] base1_reg;
    coord_t [AXES-1:0][2:0] l1_reg;
    prod_t  [AXES-1:0][1:0] prod3_reg;
    coord_t [AXES-1:0][1:0] base3_reg;
    coord_t [AXES-1:0][1:0] l2_reg;
    prod_t  [AXES-1:0]      prod5_reg;
    coord_t [AXES-1:0]      base5_reg;
    coord_t [AXES-1:0]      out_reg;

    assign adv     = !v6_reg || pt.ready;
    assign issue   = adv && job_valid;
    assign last_i  = (i_reg == job.d);
    assign job_pop = issue && last_i;

    assign rsum   = {1'b0, r_reg} + {1'b0, job.r0};
    assign carry  = (rsum >= {1'b0, job.d});
    assign t_step = t_reg + job.q0 + T_W'(carry);

    always_comb
    begin
        i_next = i_reg;
        t_next = t_reg;
        r_next = r_reg;
        if (issue) begin
            if (last_i) begin
                i_next = '0;
                t_next = '0;
                r_next = '0;
            end else begin
                i_next = i_reg + IDX_W'(1);
                t_next = t_step;
                r_next = carry ? IDX_W'(rsum - {1'b0, job.d}) : rsum[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            i_reg  <= '0;
            t_reg  <= '0;
            r_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            i_reg <= i_next;
            t_reg <= t_next;
            r_reg <= r_next;
            if (adv) begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            m1_reg.idx  <= i_reg;
            m1_reg.last <= last_i;
            t1_reg      <= t_reg;
            m2_reg      <= m1_reg;
            t2_reg      <= t1_reg;
            m3_reg      <= m2_reg;
            t3_reg      <= t2_reg;
            m4_reg      <= m3_reg;
            t4_reg      <= t3_reg;
            m5_reg      <= m4_reg;
            m6_reg      <= m5_reg;
            for (int ax = 0; ax < AXES; ax++) begin
                for (int k = 0; k < 3; k++) begin
                    prod1_reg[ax][k] <= lerp_mul(job.cp[k][ax], job.cp[k+1][ax], t_reg);
                    base1_reg[ax][k] <= job.cp[k][ax];
                    l1_reg[ax][k]    <= lerp_sum(base1_reg[ax][k], prod1_reg[ax][k]);
                end
                for (int k = 0; k < 2; k++) begin
                    prod3_reg[ax][k] <= lerp_mul(l1_reg[ax][k], l1_reg[ax][k+1], t2_reg);
                    base3_reg[ax][k] <= l1_reg[ax][k];
                    l2_reg[ax][k]    <= lerp_sum(base3_reg[ax][k], prod3_reg[ax][k]);
                end
                prod5_reg[ax] <= lerp_mul(l2_reg[ax][0], l2_reg[ax][1], t4_reg);
                base5_reg[ax] <= l2_reg[ax][0];
                out_reg[ax]   <= lerp_sum(base5_reg[ax], prod5_reg[ax]);
            end
        end
    end

    assign pt.valid        = v6_reg;
    assign pt.point_x      = out_reg[0];
    assign pt.point_y      = out_reg[1];
    assign pt.point_z      = out_reg[2];
    assign pt.sample_index = m6_reg.idx;
    assign pt.last_point   = m6_reg.last;

endmodule
`default_nettype wire

// File: src/cubic_bezier_sampler_top.sv
// Top level of the cubic Bezier sampler: front end, job queue and sample engine.
// Depends on cbs_pkg, cbs_if, cbs_front, cbs_queue and cbs_back.
`timescale 1ns / 1ps
`default_nettype none
// Each control set word yields point_count curve point words (count clamped to 2..64),
// one per cycle from a six-stage lerp pipeline while pt.ready is high and a job waits.
// The front end takes each control set through accept, a 17-step bit-serial divide for
// the parameter step and a queue push; a two-entry queue lets the front end take the
// next set while the engine still emits points. point_count must be written only while
// idle, by the user; the block itself does not enforce it.
module cubic_bezier_sampler_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    cbs_ctrl_if.sink        cp,
    cbs_point_if.source     pt
);
    import cbs_pkg::*;

    logic       push_valid, push_ready, pop_valid, pop_ready;
    job_t       push_job, pop_job;
    fifo_stat_t q_stat;

    cbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cp         (cp),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    cbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready),
        .stat       (q_stat)
    );

    cbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop_ready),
        .pt        (pt)
    );

    a_last_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid && pt.last_point |-> pt.sample_index != '0)
        else $error("last point word carries sample index zero");

    a_top_index_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid && !pt.last_point |-> pt.sample_index != IDX_W'(MAX_POINTS - 1))
        else $error("highest sample index without last mark");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= 2'(QUEUE_DEPTH) && (q_stat.full == (q_stat.count == 2'(QUEUE_DEPTH)))
        && (q_stat.empty == (q_stat.count == '0)))
        else $error("job queue count out of range");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cp.valid && cp.ready |=> !cp.ready)
        else $error("front end ready right after accepting a word");

endmodule
`default_nettype wire

// File: tb/sv/tb_cubic_bezier_sampler_top.sv
// Testbench for cubic_bezier_sampler_top: drives control point sets, predicts every
// curve point word and checks the output stream in order under several count settings.
// Depends on cbs_pkg, cbs_if and the sampler RTL.
`timescale 1ns / 1ps
module tb_cubic_bezier_sampler_top;
    import cbs_pkg::*;

    typedef coord_t [0:11] ctrl_set_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        idx_t   idx;
        logic   last;
    } point_word_t;

    typedef struct packed {
        logic              wr;
        logic [CFG_W-1:0]  count;
        logic              typed;
        coord_t [0:2]      k;
        ctrl_set_t         cp;
    } dir_row_t;

    localparam int     DIR_ROWS    = 15;
    localparam int     PHASES      = 10;
    localparam int     HOLD_CYCLES = 400;
    localparam coord_t C_MAX       = 32'sh7fff_ffff;
    localparam coord_t C_MIN       = 32'sh8000_0000;
    localparam coord_t C_ZERO      = 32'sh0000_0000;
    localparam coord_t C_ONE       = 32'sh0001_0000;
    localparam coord_t C_NEG1      = -32'sh0000_0001;

    typedef enum int { IDLE_NONE, IDLE_SRC, IDLE_DST, IDLE_BOTH } idle_mode_t;

    localparam int         PH_COUNT [PHASES] = '{5, 2, 16, 64, 0, 127, 1, -1, 3, -1};
    localparam int         PH_ITEMS [PHASES] = '{50, 50, 50, 20, 40, 10, 40, 60, 50, 60};
    localparam idle_mode_t PH_MODE  [PHASES] = '{IDLE_NONE, IDLE_SRC, IDLE_DST, IDLE_BOTH,
                                                 IDLE_BOTH, IDLE_NONE, IDLE_DST, IDLE_BOTH,
                                                 IDLE_NONE, IDLE_SRC};
    localparam bit         PH_HOLD  [PHASES] = '{1, 0, 0, 0, 0, 0, 0, 0, 1, 0};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    cbs_ctrl_if  ctrl_bus ();
    cbs_point_if point_bus ();

    cubic_bezier_sampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cp        (ctrl_bus.sink),
        .pt        (point_bus.source)
    );

    point_word_t      expected_points [$];
    logic [CFG_W-1:0] count_model;
    int               mismatch_count;
    int               src_idle_pct;
    int               dst_stall_pct;
    int               hold_requests;
    int               hold_served;
    int               hold_left;
    dir_row_t         dir_rows [DIR_ROWS];

    always #6 clk = ~clk;

    function automatic int sample_total(logic [CFG_W-1:0] cnt);
        int n;
        n = int'(cnt);
        if (n < MIN_POINTS)
            n = MIN_POINTS;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        return n;
    endfunction

    function automatic longint lerp_sat(longint a, longint b, longint t);
        longint r;
        r = a + ((t * (b - a)) >>> FRACTION_BITS);
        if (r > longint'(C_MAX))
            r = longint'(C_MAX);
        if (r < longint'(C_MIN))
            r = longint'(C_MIN);
        return r;
    endfunction

    function automatic point_word_t bezier_sample(ctrl_set_t s, int i, int n);
        point_word_t w;
        coord_t      res [3];
        longint      t;
        longint      a;
        longint      b;
        longint      c;
        longint      d;
        longint      e;
        t = (longint'(i) << FRACTION_BITS) / longint'(n - 1);
        for (int ax = 0; ax < AXES; ax++)
        begin
            a = lerp_sat(longint'($signed(s[ax])), longint'($signed(s[3 + ax])), t);
            b = lerp_sat(longint'($signed(s[3 + ax])), longint'($signed(s[6 + ax])), t);
            c = lerp_sat(longint'($signed(s[6 + ax])), longint'($signed(s[9 + ax])), t);
            d = lerp_sat(a, b, t);
            e = lerp_sat(b, c, t);
            res[ax] = coord_t'(lerp_sat(d, e, t));
        end
        w.x    = res[0];
        w.y    = res[1];
        w.z    = res[2];
        w.idx  = idx_t'(i);
        w.last = (i == n - 1);
        return w;
    endfunction

    function automatic coord_t random_coord();
        coord_t v;
        case ($urandom_range(9))
            0: v = C_MAX;
            1: v = C_MIN;
            2: v = $urandom_range(1) ? C_ZERO : C_NEG1;
            3, 4: v = coord_t'($signed($urandom_range(0, 1048575)) - 524288);
            default: v = coord_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic ctrl_set_t random_set();
        ctrl_set_t s;
        for (int j = 0; j < 12; j++)
        begin
            s[j] = random_coord();
        end
        return s;
    endfunction

    task automatic push_expected(input ctrl_set_t s, input logic typed,
                                 input coord_t [0:2] k);
        point_word_t w;
        int          n;
        n = sample_total(count_model);
        for (int i = 0; i < n; i++)
        begin
            w = bezier_sample(s, i, n);
            if (typed)
            begin
                w.x = k[0];
                w.y = k[1];
                w.z = k[2];
            end
            expected_points.push_back(w);
        end
    endtask

    task automatic offer_set(input ctrl_set_t s, input logic typed, input coord_t [0:2] k);
        while ($urandom_range(99) < src_idle_pct)
        begin
            ctrl_bus.valid <= 1'b0;
            @(posedge clk);
        end
        ctrl_bus.valid <= 1'b1;
        ctrl_bus.p0_x  <= s[0];
        ctrl_bus.p0_y  <= s[1];
        ctrl_bus.p0_z  <= s[2];
        ctrl_bus.p1_x  <= s[3];
        ctrl_bus.p1_y  <= s[4];
        ctrl_bus.p1_z  <= s[5];
        ctrl_bus.p2_x  <= s[6];
        ctrl_bus.p2_y  <= s[7];
        ctrl_bus.p2_z  <= s[8];
        ctrl_bus.p3_x  <= s[9];
        ctrl_bus.p3_y  <= s[10];
        ctrl_bus.p3_z  <= s[11];
        do
            @(posedge clk);
        while (!ctrl_bus.ready);
        push_expected(s, typed, k);
    endtask

    task automatic drain_points();
        ctrl_bus.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        drain_points();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        count_model = v;
    endtask

    task automatic load_table();
        dir_rows[0]  = '{wr: 1'b0, count: 7'd0, typed: 1'b1, k: {3{C_ZERO}},
                         cp: {12{C_ZERO}}};
        dir_rows[1]  = '{wr: 1'b0, count: 7'd0, typed: 1'b1, k: {3{C_MAX}},
                         cp: {12{C_MAX}}};
        dir_rows[2]  = '{wr: 1'b0, count: 7'd0, typed: 1'b1, k: {3{C_MIN}},
                         cp: {12{C_MIN}}};
        dir_rows[3]  = '{wr: 1'b0, count: 7'd0, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {{3{C_MIN}}, {3{C_MAX}}, {3{C_MIN}}, {3{C_MAX}}}};
        dir_rows[4]  = '{wr: 1'b0, count: 7'd0, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {{3{C_MAX}}, {3{C_MIN}}, {3{C_MAX}}, {3{C_MIN}}}};
        dir_rows[5]  = '{wr: 1'b1, count: 7'd0, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {C_MIN, C_MAX, C_ZERO, C_MAX, C_ZERO, C_MIN,
                              C_ZERO, C_MIN, C_MAX, C_NEG1, C_ONE, C_MIN}};
        dir_rows[6]  = '{wr: 1'b1, count: 7'd1, typed: 1'b1,
                         k: {C_ONE, -C_ONE, 32'sh1234_5678},
                         cp: {4{C_ONE, -C_ONE, 32'sh1234_5678}}};
        dir_rows[7]  = '{wr: 1'b1, count: 7'd2, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {{3{32'sh5555_5555}}, {3{32'shAAAA_AAAA}},
                              {3{32'sh5555_5555}}, {3{32'shAAAA_AAAA}}}};
        dir_rows[8]  = '{wr: 1'b1, count: 7'd64, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {C_MIN, C_ZERO, C_MAX, C_MAX, C_MIN, C_ZERO,
                              C_ZERO, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX}};
        dir_rows[9]  = '{wr: 1'b1, count: 7'd65, typed: 1'b1,
                         k: {C_NEG1, 32'sh0000_0001, 32'sh0000_8000},
                         cp: {4{C_NEG1, 32'sh0000_0001, 32'sh0000_8000}}};
        dir_rows[10] = '{wr: 1'b1, count: 7'd127, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {C_ZERO, C_ZERO, C_ZERO, C_ONE, 2 * C_ONE, 3 * C_ONE,
                              2 * C_ONE, 4 * C_ONE, 6 * C_ONE,
                              3 * C_ONE, 6 * C_ONE, 9 * C_ONE}};
        dir_rows[11] = '{wr: 1'b1, count: 7'd3, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {C_NEG1, C_ONE, C_MIN, C_ZERO, C_NEG1, C_MAX,
                              C_MAX, C_ZERO, C_NEG1, C_ONE, C_MAX, C_ZERO}};
        dir_rows[12] = '{wr: 1'b1, count: 7'd63, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {C_MAX, C_MAX, C_MIN, C_MIN, C_ZERO, C_ZERO,
                              C_ZERO, C_MIN, C_MAX, C_MAX, C_NEG1, C_ONE}};
        dir_rows[13] = '{wr: 1'b1, count: 7'd16, typed: 1'b1, k: {3{C_NEG1}},
                         cp: {12{C_NEG1}}};
        dir_rows[14] = '{wr: 1'b0, count: 7'd0, typed: 1'b0, k: {3{C_ZERO}},
                         cp: {32'sh0000_0003, -32'sh0000_0005, 32'sh0000_0007,
                              -32'sh0000_0011, 32'sh0000_0013, -32'sh0000_0017,
                              32'sh0000_001d, -32'sh0000_001f, 32'sh0000_0025,
                              -32'sh0000_0029, 32'sh0000_002b, -32'sh0000_002f}};
    endtask

    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left       = hold_left - 1;
            point_bus.ready <= 1'b0;
        end
        else
        begin
            point_bus.ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_points
        point_word_t want;
        if (rst_n && point_bus.valid && point_bus.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("point word with nothing expected: index %0d", point_bus.sample_index);
                mismatch_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (point_bus.point_x !== want.x)
                begin
                    $error("point_x: expected %0d, actual %0d", want.x, point_bus.point_x);
                    mismatch_count++;
                end
                if (point_bus.point_y !== want.y)
                begin
                    $error("point_y: expected %0d, actual %0d", want.y, point_bus.point_y);
                    mismatch_count++;
                end
                if (point_bus.point_z !== want.z)
                begin
                    $error("point_z: expected %0d, actual %0d", want.z, point_bus.point_z);
                    mismatch_count++;
                end
                if (point_bus.sample_index !== want.idx)
                begin
                    $error("sample_index: expected %0d, actual %0d", want.idx,
                           point_bus.sample_index);
                    mismatch_count++;
                end
                if (point_bus.last_point !== want.last)
                begin
                    $error("last_point: expected %0d, actual %0d", want.last,
                           point_bus.last_point);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_cubic_bezier_sampler_top: errors");
        $finish;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        ctrl_bus.valid  = 1'b0;
        ctrl_bus.p0_x   = '0;
        ctrl_bus.p0_y   = '0;
        ctrl_bus.p0_z   = '0;
        ctrl_bus.p1_x   = '0;
        ctrl_bus.p1_y   = '0;
        ctrl_bus.p1_z   = '0;
        ctrl_bus.p2_x   = '0;
        ctrl_bus.p2_y   = '0;
        ctrl_bus.p2_z   = '0;
        ctrl_bus.p3_x   = '0;
        ctrl_bus.p3_y   = '0;
        ctrl_bus.p3_z   = '0;
        point_bus.ready = 1'b0;
        count_model     = CFG_W'(CNT_RESET);
        mismatch_count  = 0;
        src_idle_pct    = 0;
        dst_stall_pct   = 0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        load_table();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].wr)
                write_count(dir_rows[r].count);
            offer_set(dir_rows[r].cp, dir_rows[r].typed, dir_rows[r].k);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (PH_COUNT[p] < 0)
                write_count(CFG_W'($urandom_range(2, 24)));
            else
                write_count(CFG_W'(PH_COUNT[p]));
            src_idle_pct  = (PH_MODE[p] == IDLE_SRC) ? 51 : (PH_MODE[p] == IDLE_BOTH) ? 31 : 0;
            dst_stall_pct = (PH_MODE[p] == IDLE_DST) ? 51 : (PH_MODE[p] == IDLE_BOTH) ? 31 : 0;
            if (PH_HOLD[p])
                hold_requests++;
            for (int n = 0; n < PH_ITEMS[p]; n++)
                offer_set(random_set(), 1'b0, {3{C_ZERO}});
        end

        drain_points();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_cubic_bezier_sampler_top: clean");
        else
            $display("tb_cubic_bezier_sampler_top: errors");
        $finish;
    end

endmodule
